### rtl/mvm_pkg.sv
`timescale 1ns / 1ps

package mvm_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_ROWS_DEF     = 64;
    localparam int MAX_COLS_DEF     = 64;
    localparam int ELEMENT_BITS_DEF = 16;

    // fixed field widths of the result and configuration channels
    localparam int ROW_INDEX_BITS = 6;
    localparam int DOT_BITS       = 38;
    localparam int CFG_DATA_BITS  = 7;
    localparam int OUT_DATA_BITS  = ((ROW_INDEX_BITS + DOT_BITS + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } cfg_reg_t;

    // per-product control that travels with the data through the pipeline
    typedef struct packed {
        logic                      valid;
        logic                      first_col;
        logic                      last_col;
        logic                      last_row;
        logic [ROW_INDEX_BITS-1:0] row;
    } mvm_ctl_t;

endpackage

### rtl/mvm_vec_cell.sv
`timescale 1ns / 1ps

module mvm_vec_cell #(
    parameter int ELEMENT_BITS = mvm_pkg::ELEMENT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           load_en,
    input  logic signed [ELEMENT_BITS-1:0] load_data,
    input  logic                           shift_en,
    input  logic                           wrap_sel,
    input  logic signed [ELEMENT_BITS-1:0] neighbor_data,
    input  logic signed [ELEMENT_BITS-1:0] wrap_data,
    output logic signed [ELEMENT_BITS-1:0] value
);

    logic signed [ELEMENT_BITS-1:0] value_reg;
    logic signed [ELEMENT_BITS-1:0] value_next;

    // load from the input stream, or take the value from the next cell down the ring
    always_comb
    begin
        value_next = value_reg;
        if (load_en)
        begin
            value_next = load_data;
        end
        else if (shift_en)
        begin
            value_next = wrap_sel ? wrap_data : neighbor_data;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/mvm_mac.sv
`timescale 1ns / 1ps

module mvm_mac #(
    parameter int ELEMENT_BITS = mvm_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   stall,
    input  mvm_pkg::mvm_ctl_t                      in_ctl,
    input  logic signed [ELEMENT_BITS-1:0]         mat_data,
    input  logic signed [ELEMENT_BITS-1:0]         vec_data,
    output logic                                   res_valid,
    output logic [mvm_pkg::ROW_INDEX_BITS-1:0]     res_row,
    output logic signed [mvm_pkg::DOT_BITS-1:0]    res_dot,
    output logic                                   res_last
);

    import mvm_pkg::*;

    localparam int PROD_BITS = 2 * ELEMENT_BITS;

    logic signed [PROD_BITS-1:0] prod_full;
    logic signed [DOT_BITS-1:0]  prod_reg;
    mvm_ctl_t                    prod_ctl_reg;
    logic signed [DOT_BITS-1:0]  acc_reg;
    logic signed [DOT_BITS-1:0]  acc_next;
    logic                        res_valid_reg;
    logic [ROW_INDEX_BITS-1:0]   res_row_reg;
    logic signed [DOT_BITS-1:0]  res_dot_reg;
    logic                        res_last_reg;

    // multiply stage
    assign prod_full = mat_data * vec_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
        end
        else if (!stall)
        begin
            prod_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            prod_reg <= DOT_BITS'(prod_full);
        end
    end

    // accumulate stage, restarts on the first column of a row
    assign acc_next = prod_ctl_reg.first_col ? prod_reg : acc_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        if (!stall && prod_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // result register, loaded on the last column of a row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            res_valid_reg <= prod_ctl_reg.valid && prod_ctl_reg.last_col;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall && prod_ctl_reg.valid && prod_ctl_reg.last_col)
        begin
            res_row_reg  <= prod_ctl_reg.row;
            res_dot_reg  <= acc_next;
            res_last_reg <= prod_ctl_reg.last_row;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_row   = res_row_reg;
    assign res_dot   = res_dot_reg;
    assign res_last  = res_last_reg;

endmodule

### rtl/matrix_vector_multiply.sv
`timescale 1ns / 1ps

// Matrix-vector multiplier. Stream items with tuser 0 load matrix elements in row-major
// order, items with tuser 1 load vector elements; extra items of a kind that is already
// complete are taken and dropped. Load items are taken one per cycle. The item that
// completes both loads starts a pass of row_count * col_count products through a single
// multiply-accumulate unit fed by the matrix memory and by a ring of vector cells that
// rotates one place per cycle unless the master side stalls; one result per row follows,
// row_index ascending, tlast on the final row. The slave side is not ready during the
// pass, and a stalled master side freezes the pass. Size registers read 0 as 1 and
// saturate at the maximum.

module matrix_vector_multiply #(
    parameter int MAX_ROWS     = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS     = mvm_pkg::MAX_COLS_DEF,
    parameter int ELEMENT_BITS = mvm_pkg::ELEMENT_BITS_DEF,
    localparam int IN_DATA_BITS = ((ELEMENT_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  mvm_pkg::cfg_reg_t                   cfg_index,
    input  logic [mvm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // load stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_DATA_BITS-1:0]             s_tdata,   // element, zero padding
    input  logic                                s_tuser,   // action
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mvm_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // row_index, dot_product, zero padding
    output logic                                m_tlast    // last_row
);

    import mvm_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MLW   = $clog2(DEPTH + 1);
    localparam int VLW   = $clog2(MAX_COLS + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ERW   = $clog2(MAX_ROWS + 1);
    localparam int ECW   = $clog2(MAX_COLS + 1);
    localparam int PAD_BITS = OUT_DATA_BITS - ROW_INDEX_BITS - DOT_BITS;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CFG_DATA_BITS-1:0] row_count_reg;
    logic [CFG_DATA_BITS-1:0] col_count_reg;
    logic [MLW-1:0]           mat_loaded_reg;
    logic [MLW-1:0]           mat_loaded_next;
    logic [VLW-1:0]           vec_loaded_reg;
    logic [VLW-1:0]           vec_loaded_next;
    logic [AW-1:0]            addr_reg;
    logic [RW-1:0]            row_reg;
    logic [CW-1:0]            col_reg;

    logic [ERW-1:0]           rows;
    logic [ECW-1:0]           cols;
    logic [MLW-1:0]           total;
    logic                     in_xfer;
    logic                     mat_wr;
    logic                     vec_wr;
    logic                     job_start;
    logic                     stall;
    logic                     issue;
    logic                     is_last_col;
    logic                     is_last_row;
    mvm_ctl_t                 issue_ctl;
    mvm_ctl_t                 rd_ctl_reg;
    logic signed [ELEMENT_BITS-1:0] element;
    logic signed [ELEMENT_BITS-1:0] mat_rd_reg;
    logic signed [ELEMENT_BITS-1:0] vec_rd_reg;
    logic signed [ELEMENT_BITS-1:0] mat_mem [DEPTH];
    logic signed [ELEMENT_BITS-1:0] cell_val [MAX_COLS];

    logic                     res_valid;
    logic [ROW_INDEX_BITS-1:0] res_row;
    logic signed [DOT_BITS-1:0] res_dot;
    logic                     res_last;

    // effective sizes: zero acts as one, large values saturate
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows = ERW'(1);
        end
        else if (int'(row_count_reg) > MAX_ROWS)
        begin
            rows = ERW'(MAX_ROWS);
        end
        else
        begin
            rows = ERW'(row_count_reg);
        end
        if (col_count_reg == '0)
        begin
            cols = ECW'(1);
        end
        else if (int'(col_count_reg) > MAX_COLS)
        begin
            cols = ECW'(MAX_COLS);
        end
        else
        begin
            cols = ECW'(col_count_reg);
        end
    end

    assign total = MLW'(rows) * MLW'(cols);

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_DATA_BITS'(1);
            col_count_reg <= CFG_DATA_BITS'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data;
                REG_COL_COUNT: col_count_reg <= cfg_data;
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    // load side
    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign element  = s_tdata[ELEMENT_BITS-1:0];
    assign mat_wr   = in_xfer && !s_tuser && (mat_loaded_reg < total);
    assign vec_wr   = in_xfer && s_tuser && (VLW'(vec_loaded_reg) < VLW'(cols));

    assign mat_loaded_next = mat_wr ? mat_loaded_reg + MLW'(1) : mat_loaded_reg;
    assign vec_loaded_next = vec_wr ? vec_loaded_reg + VLW'(1) : vec_loaded_reg;
    assign job_start = in_xfer && (mat_loaded_next >= total)
                       && (VLW'(vec_loaded_next) >= VLW'(cols));

    // pass control
    assign stall       = res_valid && !m_tready;
    assign issue       = (state_reg == ST_RUN) && !stall;
    assign is_last_col = (col_reg == CW'(cols - ECW'(1)));
    assign is_last_row = (row_reg == RW'(rows - ERW'(1)));

    always_comb
    begin
        issue_ctl.valid     = issue;
        issue_ctl.first_col = (col_reg == '0);
        issue_ctl.last_col  = is_last_col;
        issue_ctl.last_row  = is_last_row;
        issue_ctl.row       = ROW_INDEX_BITS'(row_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (job_start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue && is_last_col && is_last_row)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            mat_loaded_reg <= '0;
            vec_loaded_reg <= '0;
            addr_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_start)
            begin
                mat_loaded_reg <= '0;
                vec_loaded_reg <= '0;
                addr_reg       <= '0;
                row_reg        <= '0;
                col_reg        <= '0;
            end
            else
            begin
                mat_loaded_reg <= mat_loaded_next;
                vec_loaded_reg <= vec_loaded_next;
                if (issue)
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (is_last_col)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + RW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // matrix memory, row-major at the load count
    always_ff @(posedge clk)
    begin
        if (mat_wr)
        begin
            mat_mem[mat_loaded_reg[AW-1:0]] <= element;
        end
        if (issue)
        begin
            mat_rd_reg <= mat_mem[addr_reg];
            vec_rd_reg <= cell_val[0];
        end
    end

    // read stage control, frozen with the rest of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ctl_reg <= '0;
        end
        else if (!stall)
        begin
            rd_ctl_reg <= issue_ctl;
        end
    end

    // ring of vector cells: cell 0 feeds the multiplier, the ring closes at cols - 1
    for (genvar i = 0; i < MAX_COLS; i++)
    begin : g_cell
        logic signed [ELEMENT_BITS-1:0] neighbor;
        logic                           cell_load;
        logic                           cell_shift;
        logic                           cell_wrap;

        if (i == MAX_COLS - 1)
        begin : g_end
            assign neighbor = cell_val[0];
        end
        else
        begin : g_mid
            assign neighbor = cell_val[i+1];
        end

        assign cell_load  = vec_wr && (vec_loaded_reg == VLW'(i));
        assign cell_shift = issue && (ECW'(i) < cols);
        assign cell_wrap  = (ECW'(i) == cols - ECW'(1));

        mvm_vec_cell #(
            .ELEMENT_BITS (ELEMENT_BITS)
        ) u_cell (
            .clk           (clk),
            .load_en       (cell_load),
            .load_data     (element),
            .shift_en      (cell_shift),
            .wrap_sel      (cell_wrap),
            .neighbor_data (neighbor),
            .wrap_data     (cell_val[0]),
            .value         (cell_val[i])
        );
    end

    // multiply-accumulate and result register
    mvm_mac #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .stall     (stall),
        .in_ctl    (rd_ctl_reg),
        .mat_data  (mat_rd_reg),
        .vec_data  (vec_rd_reg),
        .res_valid (res_valid),
        .res_row   (res_row),
        .res_dot   (res_dot),
        .res_last  (res_last)
    );

    // result stream
    assign m_tvalid = res_valid;
    assign m_tdata  = {{PAD_BITS{1'b0}}, res_dot, res_row};
    assign m_tlast  = res_last;

endmodule
